[hdl/binary_reversal_prime_classifier_top_macros.svh]
// Assertion macros for the checker file.
`ifndef BINARY_REVERSAL_PRIME_CLASSIFIER_TOP_MACROS_SVH
`define BINARY_REVERSAL_PRIME_CLASSIFIER_TOP_MACROS_SVH

// Same-cycle implication under a synchronous reset.
`define BRPC_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("brpc assertion failed");

// Next-cycle implication under a synchronous reset.
`define BRPC_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("brpc assertion failed");

`endif

[hdl/brpc_pkg.sv]
`default_nettype none
package brpc_pkg;

   localparam int NUM_W      = 32;
   localparam int DIV_W      = 16;
   localparam int SQ_W       = 2 * DIV_W;
   localparam int CAT_W      = 3;
   localparam int RADIX_BITS = 4;
   localparam int REM_STEPS  = NUM_W / RADIX_BITS;

   localparam logic [CAT_W-1:0] CAT_LOAD      = 3'd0;
   localparam logic [CAT_W-1:0] CAT_SELF      = 3'd1;
   localparam logic [CAT_W-1:0] CAT_PAIR      = 3'd2;
   localparam logic [CAT_W-1:0] CAT_SMALLER   = 3'd3;
   localparam logic [CAT_W-1:0] CAT_COMPOSITE = 3'd4;

   localparam logic [NUM_W-1:0] CNT_MAX = '1;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] numer;
      logic [DIV_W-1:0] divisor;
   } rem_ctrl_type;

   typedef struct packed {
      logic            done;
      logic            rem_zero;
      logic [SQ_W-1:0] square;
   } rem_stat_type;

endpackage
`default_nettype wire

[hdl/brpc_ifs.sv]
`default_nettype none
interface brpc_req_if import brpc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             action;
   logic [NUM_W-1:0] candidate;
   logic [DIV_W-1:0] divisor;

   modport source(output valid, action, candidate, divisor, input ready);
   modport sink(input valid, action, candidate, divisor, output ready);
endinterface

interface brpc_rsp_if import brpc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [NUM_W-1:0] reversed_value;
   logic [CAT_W-1:0] category;
   logic             table_short;
   logic [NUM_W-1:0] self_total;
   logic [NUM_W-1:0] pair_total;
   logic [NUM_W-1:0] unmirrored_total;

   modport source(output valid, reversed_value, category, table_short, self_total,
                  pair_total, unmirrored_total, input ready);
   modport sink(input valid, reversed_value, category, table_short, self_total,
                pair_total, unmirrored_total, output ready);
endinterface
`default_nettype wire

[hdl/brpc_ram.sv]
`default_nettype none
module brpc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

[hdl/brpc_rem_unit.sv]
`default_nettype none
module brpc_rem_unit import brpc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire rem_ctrl_type ctrl,
   output rem_stat_type      stat
);

   localparam int STEP_W = $clog2(REM_STEPS);

   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dvs_ff;
   logic [SQ_W-1:0]   sq_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;

   // Restoring remainder, RADIX_BITS numerator bits per cycle while busy.
   always_comb begin
      logic [NUM_W-1:0] n;
      logic [DIV_W-1:0] r;
      logic [DIV_W:0]   t;
      n = num_ff;
      r = rem_ff;
      for (int k = 0; k < RADIX_BITS; k++) begin
         t = {r, n[NUM_W-1]};
         n = {n[NUM_W-2:0], 1'b0};
         if (t >= {1'b0, dvs_ff}) begin
            t = t - {1'b0, dvs_ff};
         end
         r = t[DIV_W-1:0];
      end
      num_in = n;
      rem_in = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (ctrl.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         if (step_ff == STEP_W'(REM_STEPS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         num_ff <= ctrl.numer;
         rem_ff <= '0;
         dvs_ff <= ctrl.divisor;
         sq_ff  <= SQ_W'(ctrl.divisor) * SQ_W'(ctrl.divisor);
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign stat.done     = done_ff;
   assign stat.rem_zero = (rem_ff == '0);
   assign stat.square   = sq_ff;

endmodule
`default_nettype wire

[hdl/binary_reversal_prime_classifier_top.sv]
// Channel | Dir | Handshake    | Word
// req_ch  | in  | valid/ready  | action, candidate, divisor
// rsp_ch  | out | valid/ready  | reversed_value, category, table_short, three totals
//
// Load word: the accepting edge moves to the finish step, which posts the result.
// Classify word: the candidate is reversed, then each divisor visited is fetched,
// read and run in the shared remainder unit at 4 quotient bits a cycle, and the
// finish step posts the result. A full walk visits all 8192 entries by default.
// reset is synchronous; it clears the sequencer, fill count, totals and rsp valid;
// the table RAM is not cleared, only loaded entries are ever read.
// req ready is high only while idle; a stalled rsp holds the finish step.
`default_nettype none
module binary_reversal_prime_classifier_top import brpc_pkg::*; #(
   parameter int TABLE_DEPTH = 8192
) (
   input wire logic  clock,
   input wire logic  reset,
   brpc_req_if.sink   req_ch,
   brpc_rsp_if.source rsp_ch
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_REV   = 3'd1;
   localparam logic [2:0] ST_FETCH = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] idx_ff, idx_in;
   logic [NUM_W-1:0]  cand_ff, cand_in;
   logic [NUM_W-1:0]  shift_ff, shift_in;
   logic [NUM_W-1:0]  rev_ff, rev_in;
   logic              load_ff, load_in;
   logic              prime_ff, prime_in;
   logic              short_ff, short_in;
   logic [NUM_W-1:0]  self_ff, self_in;
   logic [NUM_W-1:0]  pair_ff, pair_in;
   logic [NUM_W-1:0]  unm_ff, unm_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [NUM_W-1:0]  rsp_rev_ff;
   logic [CAT_W-1:0]  rsp_cat_ff, rsp_cat_in;
   logic              rsp_short_ff;

   logic              accept;
   logic              slot_free;
   logic              finish;
   logic              tbl_wr;
   logic              tbl_rd;
   logic [DIV_W-1:0]  tbl_data;
   rem_ctrl_type      rem_ctrl;
   rem_stat_type      rem_stat;

   assign req_ch.ready = (state_ff == ST_IDLE) && !reset;
   assign accept       = req_ch.valid && req_ch.ready;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign finish       = (state_ff == ST_DONE) && slot_free;
   // Drop loads once the table is full.
   assign tbl_wr       = accept && !req_ch.action && (fill_ff < FILL_W'(TABLE_DEPTH));
   assign tbl_rd       = (state_ff == ST_FETCH) && (idx_ff < fill_ff);

   brpc_ram #(
      .WIDTH(DIV_W),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (tbl_wr),
      .wr_addr(fill_ff[ADDR_W-1:0]),
      .wr_data(req_ch.divisor),
      .rd_en  (tbl_rd),
      .rd_addr(idx_ff[ADDR_W-1:0]),
      .rd_data(tbl_data)
   );

   brpc_rem_unit u_rem (
      .clock(clock),
      .reset(reset),
      .ctrl (rem_ctrl),
      .stat (rem_stat)
   );

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      cand_in       = cand_ff;
      shift_in      = shift_ff;
      rev_in        = rev_ff;
      load_in       = load_ff;
      prime_in      = prime_ff;
      short_in      = short_ff;
      rem_ctrl      = '0;
      rem_ctrl.numer   = rev_ff;
      rem_ctrl.divisor = tbl_data;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cand_in  = req_ch.candidate;
               shift_in = req_ch.candidate;
               rev_in   = '0;
               short_in = 1'b0;
               prime_in = 1'b0;
               load_in  = !req_ch.action;
               if (tbl_wr) begin
                  fill_in = fill_ff + 1'b1;
               end
               state_in = req_ch.action ? ST_REV : ST_DONE;
            end
         end
         ST_REV: begin
            // Shift the candidate out LSB first until no set bit remains.
            if (shift_ff == '0) begin
               idx_in   = '0;
               state_in = ST_FETCH;
            end else begin
               rev_in   = {rev_ff[NUM_W-2:0], shift_ff[0]};
               shift_in = {1'b0, shift_ff[NUM_W-1:1]};
            end
         end
         ST_FETCH: begin
            if (idx_ff >= fill_ff) begin
               // Table ran out: count as prime, flag it.
               prime_in = 1'b1;
               short_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // Skip zero entries.
            if (tbl_data == '0) begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_FETCH;
            end else begin
               rem_ctrl.start = 1'b1;
               state_in       = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_stat.done) begin
               if (rem_stat.rem_zero) begin
                  prime_in = 1'b0;
                  state_in = ST_DONE;
               end else if (rem_stat.square >= SQ_W'(rev_ff)) begin
                  prime_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Classify and advance the saturating totals at the finish step.
   always_comb begin
      self_in   = self_ff;
      pair_in   = pair_ff;
      unm_in    = unm_ff;
      rsp_cat_in = CAT_LOAD;
      if (!load_ff) begin
         if (!prime_ff) begin
            rsp_cat_in = CAT_COMPOSITE;
            if (unm_ff != CNT_MAX) begin
               unm_in = unm_ff + 1'b1;
            end
         end else if (rev_ff == cand_ff) begin
            rsp_cat_in = CAT_SELF;
            if (self_ff != CNT_MAX) begin
               self_in = self_ff + 1'b1;
            end
         end else if (rev_ff > cand_ff) begin
            rsp_cat_in = CAT_PAIR;
            if (pair_ff != CNT_MAX) begin
               pair_in = pair_ff + 1'b1;
            end
         end else begin
            rsp_cat_in = CAT_SMALLER;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         self_ff      <= '0;
         pair_ff      <= '0;
         unm_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish) begin
            self_ff <= self_in;
            pair_ff <= pair_in;
            unm_ff  <= unm_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      cand_ff  <= cand_in;
      shift_ff <= shift_in;
      rev_ff   <= rev_in;
      load_ff  <= load_in;
      prime_ff <= prime_in;
      short_ff <= short_in;
      if (finish) begin
         rsp_rev_ff   <= load_ff ? '0 : rev_ff;
         rsp_cat_ff   <= rsp_cat_in;
         rsp_short_ff <= short_ff && !load_ff;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.reversed_value   = rsp_rev_ff;
   assign rsp_ch.category         = rsp_cat_ff;
   assign rsp_ch.table_short      = rsp_short_ff;
   assign rsp_ch.self_total       = self_ff;
   assign rsp_ch.pair_total       = pair_ff;
   assign rsp_ch.unmirrored_total = unm_ff;

endmodule
`default_nettype wire

[hdl/brpc_checker.sv]
`default_nettype none
`include "binary_reversal_prime_classifier_top_macros.svh"
module brpc_checker import brpc_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [NUM_W-1:0] rsp_reversed_value,
   input wire logic [CAT_W-1:0] rsp_category,
   input wire logic             rsp_table_short,
   input wire logic [NUM_W-1:0] rsp_unmirrored_total
);

   `BRPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_reversed_value) && $stable(rsp_category))
   `BRPC_ASSERT_NEXT(a_one_word, clock, reset, req_valid && req_ready, !req_ready)
   `BRPC_ASSERT_IMPLY(a_load_clean, clock, reset, rsp_valid && rsp_category == CAT_LOAD, rsp_reversed_value == '0 && !rsp_table_short)
   `BRPC_ASSERT_IMPLY(a_short_prime, clock, reset, rsp_valid && rsp_table_short, rsp_category == CAT_SELF || rsp_category == CAT_PAIR || rsp_category == CAT_SMALLER)
   `BRPC_ASSERT_IMPLY(a_unm_count, clock, reset, rsp_valid && rsp_category == CAT_COMPOSITE, rsp_unmirrored_total != '0)

endmodule

bind binary_reversal_prime_classifier_top brpc_checker u_brpc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_reversed_value  (rsp_ch.reversed_value),
   .rsp_category        (rsp_ch.category),
   .rsp_table_short     (rsp_ch.table_short),
   .rsp_unmirrored_total(rsp_ch.unmirrored_total)
);
`default_nettype wire
